>>> rtl/lknt_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lknt_pkg
// Shared sizes, types and helpers of the keyed name table with
// least-recently-seen replacement.
// ----------------------------------------------------------------------------
package lknt_pkg;

    localparam int TABLE_ENTRIES = 64;
    localparam int NAME_BYTES    = 4;
    localparam int IDX_W         = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int COUNT_W       = $clog2(TABLE_ENTRIES + 1);

    localparam logic [31:0] KEY_NONE = 32'h0000_0000;
    localparam logic [31:0] KEY_BAD  = 32'hFFFF_FFFF;

    localparam logic ACT_UPDATE = 1'b0;
    localparam logic ACT_LOOKUP = 1'b1;

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_SCAN
    } state_t;

    // search word that walks down the row of cells
    typedef struct packed {
        logic              valid;
        logic              found;
        logic [IDX_W-1:0]  found_idx;
        logic [31:0]       found_name;
        logic [31:0]       min_seen;
        logic [IDX_W-1:0]  min_idx;
    } probe_t;

    // write-back broadcast to all cells
    typedef struct packed {
        logic              en;
        logic              seen_only;
        logic [IDX_W-1:0]  idx;
        logic [31:0]       key;
        logic [31:0]       name;
        logic [31:0]       seen;
    } wr_cmd_t;

    // bytes after the first zero byte are dropped
    function automatic logic [31:0] clean_name(input logic [31:0] raw);
        logic [31:0] res;
        logic        stop;
        res  = '0;
        stop = 1'b0;
        for (int b = 0; b < 4; b++)
        begin
            if (b < NAME_BYTES && !stop)
            begin
                if (raw[8*b +: 8] == 8'h00)
                    stop = 1'b1;
                else
                    res[8*b +: 8] = raw[8*b +: 8];
            end
        end
        return res;
    endfunction

endpackage
`default_nettype wire

>>> rtl/lru_keyed_name_table_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lru_keyed_name_table_top
// Keyed short-name table with least-recently-seen replacement, built as a
// row of entry cells that a search word walks through.
//
//   channel   signals                                  handshake
//   command   action node_key name_in now_time         start, busy
//   result    accepted hit name_out                    done (one cycle)
//
// Each command goes through a launch register, the search word passing
// every cell of the row, and the write-back. busy is high from the
// accepting edge until the result is strobed; a new start may be taken
// in the cycle done is high. Reset empties the table by clearing the
// entry count; no clearing pass.
// ----------------------------------------------------------------------------
module lru_keyed_name_table_top (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic        action,
    input  wire logic [31:0] node_key,
    input  wire logic [31:0] name_in,
    input  wire logic [31:0] now_time,
    output logic             done,
    output logic             accepted,
    output logic             hit,
    output logic [31:0]      name_out
);
    import lknt_pkg::*;

    state_t               state_reg;
    state_t               state_next;
    logic                 launch_reg;
    logic [COUNT_W-1:0]   count_reg;
    logic [COUNT_W-1:0]   count_next;
    logic                 done_reg;
    logic                 done_next;
    logic                 action_reg;
    logic [31:0]          key_reg;
    logic [31:0]          name_reg;
    logic [31:0]          now_reg;
    logic                 accepted_reg;
    logic                 accepted_next;
    logic                 hit_reg;
    logic                 hit_next;
    logic [31:0]          name_out_reg;
    logic [31:0]          name_out_next;
    logic                 take;
    logic                 key_ok;
    logic                 full;
    probe_t               tail;
    wr_cmd_t              wr;

    assign busy   = (state_reg != ST_IDLE);
    assign take   = start && !busy;
    assign key_ok = (key_reg != KEY_NONE) && (key_reg != KEY_BAD);
    assign full   = (count_reg == COUNT_W'(TABLE_ENTRIES));

    lknt_chain u_chain (
        .clk        (clk),
        .rst_n      (rst_n),
        .launch     (launch_reg),
        .count      (count_reg),
        .search_key (key_reg),
        .wr         (wr),
        .tail       (tail)
    );

    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        done_next     = 1'b0;
        accepted_next = accepted_reg;
        hit_next      = hit_reg;
        name_out_next = name_out_reg;
        wr            = '0;
        wr.key        = key_reg;
        wr.name       = clean_name(name_reg);
        wr.seen       = now_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (take)
                    state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                if (tail.valid)
                begin
                    state_next    = ST_IDLE;
                    done_next     = 1'b1;
                    accepted_next = 1'b0;
                    hit_next      = 1'b0;
                    name_out_next = '0;
                    if (action_reg == ACT_LOOKUP)
                    begin
                        if (tail.found)
                        begin
                            // lookup hit only refreshes the stamp
                            hit_next      = 1'b1;
                            name_out_next = tail.found_name;
                            wr.en         = 1'b1;
                            wr.seen_only  = 1'b1;
                            wr.idx        = tail.found_idx;
                        end
                    end
                    else if (key_ok)
                    begin
                        accepted_next = 1'b1;
                        wr.en         = 1'b1;
                        if (tail.found)
                        begin
                            hit_next = 1'b1;
                            wr.idx   = tail.found_idx;
                        end
                        else if (!full)
                        begin
                            wr.idx     = count_reg[IDX_W-1:0];
                            count_next = count_reg + COUNT_W'(1);
                        end
                        else
                        begin
                            wr.idx = tail.min_idx;
                        end
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            launch_reg <= 1'b0;
            count_reg  <= '0;
            done_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            launch_reg <= take;
            count_reg  <= count_next;
            done_reg   <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            action_reg <= action;
            key_reg    <= node_key;
            name_reg   <= name_in;
            now_reg    <= now_time;
        end
        accepted_reg <= accepted_next;
        hit_reg      <= hit_next;
        name_out_reg <= name_out_next;
    end

    assign done     = done_reg;
    assign accepted = accepted_reg;
    assign hit      = hit_reg;
    assign name_out = name_out_reg;

endmodule
`default_nettype wire

>>> rtl/lknt_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lknt_cell
// One table entry. Compares the passing search word against its key and
// stamp, registers the updated word for the next cell, and takes writes
// addressed to its index.
// ----------------------------------------------------------------------------
module lknt_cell (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic [lknt_pkg::IDX_W-1:0]   cell_idx,
    input  wire logic [lknt_pkg::COUNT_W-1:0] count,
    input  wire logic [31:0]             search_key,
    input  wire lknt_pkg::probe_t        probe_in,
    output lknt_pkg::probe_t             probe_out,
    input  wire lknt_pkg::wr_cmd_t       wr
);
    import lknt_pkg::*;

    logic [31:0] key_reg;
    logic [31:0] name_reg;
    logic [31:0] seen_reg;
    logic        valid_reg;
    probe_t      probe_reg;
    probe_t      probe_next;
    logic        live;

    assign live = {{(COUNT_W-IDX_W){1'b0}}, cell_idx} < count;

    always_comb
    begin
        probe_next = probe_in;
        if (live && !probe_in.found && key_reg == search_key)
        begin
            probe_next.found      = 1'b1;
            probe_next.found_idx  = cell_idx;
            probe_next.found_name = name_reg;
        end
        if (live && seen_reg < probe_in.min_seen)
        begin
            probe_next.min_seen = seen_reg;
            probe_next.min_idx  = cell_idx;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= probe_in.valid;
    end

    always_ff @(posedge clk)
    begin
        probe_reg <= probe_next;
        if (wr.en && wr.idx == cell_idx)
        begin
            seen_reg <= wr.seen;
            if (!wr.seen_only)
            begin
                key_reg  <= wr.key;
                name_reg <= wr.name;
            end
        end
    end

    always_comb
    begin
        probe_out       = probe_reg;
        probe_out.valid = valid_reg;
    end

endmodule
`default_nettype wire

>>> rtl/lknt_chain.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lknt_chain
// Row of entry cells. A search word enters at cell 0, is registered by each
// cell in turn, and leaves the last carrying the match and the oldest entry.
// ----------------------------------------------------------------------------
module lknt_chain (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    launch,
    input  wire logic [lknt_pkg::COUNT_W-1:0] count,
    input  wire logic [31:0]             search_key,
    input  wire lknt_pkg::wr_cmd_t       wr,
    output lknt_pkg::probe_t             tail
);
    import lknt_pkg::*;

    probe_t link [TABLE_ENTRIES+1];

    always_comb
    begin
        link[0]            = '0;
        link[0].valid      = launch;
        link[0].min_seen   = 32'hFFFF_FFFF;
    end

    for (genvar i = 0; i < TABLE_ENTRIES; i++)
    begin : g_cell
        lknt_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .cell_idx   (IDX_W'(i)),
            .count      (count),
            .search_key (search_key),
            .probe_in   (link[i]),
            .probe_out  (link[i+1]),
            .wr         (wr)
        );
    end

    assign tail = link[TABLE_ENTRIES];

endmodule
`default_nettype wire
